// ===== src/cus_pkg.sv =====
// Shared types, constants and the CRC-32 byte function for the upload session checker.
// Used by every module of the block; depends on nothing.
package cus_pkg;

   localparam int SLOT_COUNT  = 4;
   localparam int CHUNK_BYTES = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   localparam logic [23:0] MIN_SIZE_RESET = 24'd16;
   localparam logic [23:0] MAX_SIZE_RESET = 24'hFFFFFF;
   localparam logic [31:0] MAGIC_RESET    = 32'd0;

   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_MIN_SIZE = 2'd0;
   localparam logic [1:0] REG_MAX_SIZE = 2'd1;
   localparam logic [1:0] REG_MAGIC    = 2'd2;

   typedef enum logic [1:0] {
      MODE_BEGIN = 2'd0,
      MODE_DATA  = 2'd1,
      MODE_END   = 2'd2,
      MODE_ABORT = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      STAT_BEGUN      = 4'd0,
      STAT_DATA_OK    = 4'd1,
      STAT_COMPLETE   = 4'd2,
      STAT_ABORTED    = 4'd3,
      STAT_BAD_SLOT   = 4'd4,
      STAT_BAD_SIZE   = 4'd5,
      STAT_NO_SESSION = 4'd6,
      STAT_OFFSET     = 4'd7,
      STAT_OVERFLOW   = 4'd8,
      STAT_INCOMPLETE = 4'd9,
      STAT_CRC        = 4'd10,
      STAT_MAGIC      = 4'd11
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_CRC    = 2'd1,
      BK_RESULT = 2'd2
   } back_state_type;

   // Classified command handed from the front to the back through the queue.
   typedef struct packed {
      mode_type    mode;
      logic        bad_slot;
      logic        bad_size;
      logic [2:0]  slot;
      logic [23:0] size;
      logic [23:0] offset;
      logic [3:0]  count;
      logic [63:0] bytes;
      logic [31:0] claim;
   } cmd_type;

   // One reflected CRC-32 byte update.
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// ===== src/cus_front.sv =====
// Front end of the upload session checker: accepts items, classifies them
// (slot and size range, clamped byte count) and holds them in a short queue.
// Depends on cus_pkg.
module cus_front import cus_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // mode
   input  logic [151:0]  req_tdata,   // slot_request, announced_size, chunk_offset,
                                      // byte_count, chunk_bytes, claimed_crc, pad
   input  logic [23:0]   min_size,
   input  logic [23:0]   max_size,
   input  logic          q_pop,
   output logic          q_valid,
   output cmd_type       q_cmd
);

   cmd_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   cmd_type               cmd;
   logic                  push;
   logic [3:0]            raw_count;

   always_comb begin
      raw_count     = req_tdata[54:51];
      cmd.mode      = mode_type'(req_tuser);
      cmd.slot      = req_tdata[2:0];
      cmd.size      = req_tdata[26:3];
      cmd.offset    = req_tdata[50:27];
      cmd.bytes     = req_tdata[118:55];
      cmd.claim     = req_tdata[150:119];
      cmd.bad_slot  = {1'b0, cmd.slot} >= 4'(SLOT_COUNT);
      cmd.bad_size  = (cmd.size < min_size) || (cmd.size > max_size);
      // clamp oversized byte counts to the chunk width
      cmd.count     = (raw_count > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : raw_count;
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_cmd      = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      priority if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ===== src/cus_back.sv =====
// Back end of the upload session checker: session state, byte-serial CRC-32
// unit and the result register. Depends on cus_pkg.
module cus_back import cus_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  cmd_type       q_cmd,
   output logic          q_pop,
   input  logic [31:0]   magic_word,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [3:0]    rsp_tuser,
   output logic [87:0]   rsp_tdata
);

   back_state_type state_ff, state_in;

   logic        recv_ff, recv_in;
   logic [2:0]  slot_ff, slot_in;
   logic [23:0] exp_ff, exp_in;
   logic [23:0] rcv_ff, rcv_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] header_ff, header_in;

   // CRC loop working registers
   logic [31:0] work_ff, work_in;
   logic [63:0] shift_ff, shift_in;
   logic [23:0] pos_ff, pos_in;
   logic [3:0]  rem_ff, rem_in;

   logic        out_valid_ff, out_valid_in;
   status_type  out_status_ff, status_in;
   logic [87:0] out_data_ff;
   logic        load;
   logic        out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      recv_in   = recv_ff;
      slot_in   = slot_ff;
      exp_in    = exp_ff;
      rcv_in    = rcv_ff;
      crc_in    = crc_ff;
      header_in = header_ff;
      work_in   = work_ff;
      shift_in  = shift_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      status_in = STAT_DATA_OK;
      load      = 1'b0;
      q_pop     = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               load  = 1'b1;
               unique case (q_cmd.mode)
                  MODE_BEGIN: begin
                     priority if (q_cmd.bad_slot) begin
                        status_in = STAT_BAD_SLOT;
                     end else if (q_cmd.bad_size) begin
                        status_in = STAT_BAD_SIZE;
                     end else begin
                        recv_in   = 1'b1;
                        slot_in   = q_cmd.slot;
                        exp_in    = q_cmd.size;
                        rcv_in    = '0;
                        crc_in    = '0;
                        header_in = '0;
                        status_in = STAT_BEGUN;
                     end
                  end
                  MODE_DATA: begin
                     priority if (!recv_ff) begin
                        status_in = STAT_NO_SESSION;
                     end else if (q_cmd.offset != rcv_ff) begin
                        status_in = STAT_OFFSET;
                     end else if (({1'b0, rcv_ff} + 25'(q_cmd.count)) > {1'b0, exp_ff}) begin
                        status_in = STAT_OVERFLOW;
                     end else begin
                        // hold the result until every byte went through the CRC unit
                        load     = 1'b0;
                        work_in  = ~crc_ff;
                        shift_in = q_cmd.bytes;
                        pos_in   = rcv_ff;
                        rem_in   = q_cmd.count;
                        state_in = BK_CRC;
                     end
                  end
                  MODE_END: begin
                     priority if (!recv_ff) begin
                        status_in = STAT_NO_SESSION;
                     end else if (rcv_ff != exp_ff) begin
                        status_in = STAT_INCOMPLETE;
                     end else if (crc_ff != q_cmd.claim) begin
                        recv_in   = 1'b0;
                        status_in = STAT_CRC;
                     end else if (header_ff != magic_word) begin
                        recv_in   = 1'b0;
                        status_in = STAT_MAGIC;
                     end else begin
                        recv_in   = 1'b0;
                        status_in = STAT_COMPLETE;
                     end
                  end
                  MODE_ABORT: begin
                     recv_in   = 1'b0;
                     rcv_in    = '0;
                     status_in = STAT_ABORTED;
                  end
                  default: begin
                     status_in = STAT_ABORTED;
                  end
               endcase
            end
         end
         BK_CRC: begin
            if (rem_ff != '0) begin
               work_in = crc_byte(work_ff, shift_ff[7:0]);
               if (pos_ff < 24'd4) begin
                  header_in[{pos_ff[1:0], 3'b000} +: 8] =
                     header_ff[{pos_ff[1:0], 3'b000} +: 8] | shift_ff[7:0];
               end
               shift_in = shift_ff >> 8;
               pos_in   = pos_ff + 24'd1;
               rem_in   = rem_ff - 4'd1;
            end else begin
               state_in = BK_RESULT;
            end
         end
         BK_RESULT: begin
            if (out_free) begin
               load      = 1'b1;
               crc_in    = ~work_ff;
               rcv_in    = pos_ff;
               status_in = STAT_DATA_OK;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         recv_ff      <= 1'b0;
         slot_ff      <= '0;
         exp_ff       <= '0;
         rcv_ff       <= '0;
         crc_ff       <= '0;
         header_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         recv_ff      <= recv_in;
         slot_ff      <= slot_in;
         exp_ff       <= exp_in;
         rcv_ff       <= rcv_in;
         crc_ff       <= crc_in;
         header_ff    <= header_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      shift_ff <= shift_in;
      pos_ff   <= pos_in;
      rem_ff   <= rem_in;
      if (load) begin
         out_status_ff <= status_in;
         out_data_ff   <= {4'd0, slot_in, recv_in, crc_in, exp_in, rcv_in};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== src/crc_checked_upload_session_top.sv =====
// Upload session checker with running CRC-32: top level with the register port.
// Instantiates cus_front and cus_back; depends on cus_pkg.
//
// Usage:
//   req_*  : one command per item (begin, data chunk, end, abort), mode on tuser.
//   rsp_*  : exactly one result item per command, in order, status on tuser.
//   csr_*  : min_size at 0x0, max_size at 0x4, magic_word at 0x8; write only
//            while no command is in flight.
// Timing: an accepted item is registered in the two-entry front queue; begin,
// end and abort are taken from it and written to the result register in the
// same cycle, so their result shows from the result register. A data chunk
// holds the back end for the take from the queue, one byte per cycle through
// the CRC unit, a closing step and the result write. Sustained rate: 1 item per
// cycle for control commands while results are taken; a data chunk keeps the
// next item waiting until its result is written.
// Reset: synchronous; clears the queue, the result register and the session
// state; registers return to min_size 16, max_size 0xFFFFFF, magic 0.
// Stall: a held result keeps the back end from taking its next item, and a
// finished chunk waits for it; the queue keeps accepting until both entries fill.
module crc_checked_upload_session_top import cus_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_tuser,   // mode
   input  logic [151:0]       req_tdata,   // slot_request[2:0], announced_size[26:3],
                                           // chunk_offset[50:27], byte_count[54:51],
                                           // chunk_bytes[118:55], claimed_crc[150:119]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [3:0]         rsp_tuser,   // status
   output logic [87:0]        rsp_tdata,   // received_count[23:0], expected_count[47:24],
                                           // crc_value[79:48], session_open[80],
                                           // slot_out[83:81]
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [23:0] min_size_ff;
   logic [23:0] max_size_ff;
   logic [31:0] magic_ff;
   logic        csr_write;
   logic        q_valid;
   logic        q_pop;
   cmd_type     q_cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff <= MIN_SIZE_RESET;
         max_size_ff <= MAX_SIZE_RESET;
         magic_ff    <= MAGIC_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_MIN_SIZE: min_size_ff <= csr_pwdata[23:0];
            REG_MAX_SIZE: max_size_ff <= csr_pwdata[23:0];
            REG_MAGIC:    magic_ff    <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MIN_SIZE: csr_prdata = {8'd0, min_size_ff};
         REG_MAX_SIZE: csr_prdata = {8'd0, max_size_ff};
         REG_MAGIC:    csr_prdata = magic_ff;
         default:      csr_prdata = '0;
      endcase
   end

   cus_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .min_size   (min_size_ff),
      .max_size   (max_size_ff),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd)
   );

   cus_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .magic_word (magic_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/cus_checker.sv =====
// Port-level checks for the upload session checker, bound to its top level.
// Depends on cus_pkg.
module cus_checker import cus_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [3:0]         rsp_tuser,
   input logic [87:0]        rsp_tdata
);

   // a stalled result keeps its place and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // no result comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a begun session is open and starts empty
   a_begun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_BEGUN |-> rsp_tdata[80] && rsp_tdata[23:0] == 24'd0)
      else $error("begin left session closed or count nonzero");

   // abort closes the session and clears the count
   a_aborted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_ABORTED |-> !rsp_tdata[80] && rsp_tdata[23:0] == 24'd0)
      else $error("abort left session state behind");

   // accepted data never runs past the announced size
   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_DATA_OK |-> rsp_tdata[80] &&
         rsp_tdata[23:0] <= rsp_tdata[47:24])
      else $error("data accepted beyond announced size");

endmodule

bind crc_checked_upload_session_top cus_checker u_cus_checker (.*);
